// ===== hdl/scl_pkg.sv =====
// Shared constants, types and tables of the serial command line decoder.
`default_nettype none

package scl_pkg;

    // Line capacity and derived widths
    localparam int LINE_MAX = 10;
    localparam int CAP      = LINE_MAX - 1;
    localparam int LEN_W    = $clog2(LINE_MAX);
    localparam int IDX_W    = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int VAL_W    = 32;

    localparam logic [LEN_W-1:0] PARSE_START = LEN_W'(3);

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [7:0] ROUTE_RESET = 8'd63;

    // Result kinds
    localparam logic [1:0] KIND_DAC   = 2'd0;
    localparam logic [1:0] KIND_ROUTE = 2'd1;
    localparam logic [1:0] KIND_LED   = 2'd2;
    localparam logic [1:0] KIND_FWD   = 2'd3;

    localparam logic [3:0] DAC_MAP [8] = '{
        4'd5, 4'd6, 4'd8, 4'd7, 4'd1, 4'd4, 4'd2, 4'd3
    };

    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
        8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
        8'h01,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,
        8'h02,8'h02,8'h03,8'h03,8'h03,8'h03,8'h03,8'h03,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h05,8'h05,8'h05,
        8'h05,8'h06,8'h06,8'h06,8'h07,8'h07,8'h07,8'h08,
        8'h08,8'h08,8'h09,8'h09,8'h0A,8'h0A,8'h0B,8'h0B,
        8'h0C,8'h0C,8'h0D,8'h0D,8'h0E,8'h0F,8'h0F,8'h10,
        8'h11,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,
        8'h18,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1F,8'h20,
        8'h21,8'h23,8'h24,8'h26,8'h27,8'h29,8'h2B,8'h2C,
        8'h2E,8'h30,8'h32,8'h34,8'h36,8'h38,8'h3A,8'h3C,
        8'h3E,8'h40,8'h43,8'h45,8'h47,8'h4A,8'h4C,8'h4F,
        8'h51,8'h54,8'h57,8'h59,8'h5C,8'h5F,8'h62,8'h64,
        8'h67,8'h6A,8'h6D,8'h70,8'h73,8'h76,8'h79,8'h7C,
        8'h7F,8'h82,8'h85,8'h88,8'h8B,8'h8E,8'h91,8'h94,
        8'h97,8'h9A,8'h9C,8'h9F,8'hA2,8'hA5,8'hA7,8'hAA,
        8'hAD,8'hAF,8'hB2,8'hB4,8'hB7,8'hB9,8'hBB,8'hBE,
        8'hC0,8'hC2,8'hC4,8'hC6,8'hC8,8'hCA,8'hCC,8'hCE,
        8'hD0,8'hD2,8'hD3,8'hD5,8'hD7,8'hD8,8'hDA,8'hDB,
        8'hDD,8'hDE,8'hDF,8'hE1,8'hE2,8'hE3,8'hE4,8'hE5,
        8'hE6,8'hE7,8'hE8,8'hE9,8'hEA,8'hEB,8'hEC,8'hED,
        8'hED,8'hEE,8'hEF,8'hEF,8'hF0,8'hF1,8'hF1,8'hF2,
        8'hF2,8'hF3,8'hF3,8'hF4,8'hF4,8'hF5,8'hF5,8'hF6,
        8'hF6,8'hF6,8'hF7,8'hF7,8'hF7,8'hF8,8'hF8,8'hF8,
        8'hF9,8'hF9,8'hF9,8'hF9,8'hFA,8'hFA,8'hFA,8'hFA,
        8'hFA,8'hFB,8'hFB,8'hFB,8'hFB,8'hFB,8'hFB,8'hFC,
        8'hFC,8'hFC,8'hFC,8'hFC,8'hFC,8'hFC,8'hFC,8'hFC,
        8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,
        8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,8'hFD,8'hFE,
        8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFF,8'hFF
    };

    // Command decoded from the first two characters of the line
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DAC,
        CLS_ROUTE,
        CLS_LED,
        CLS_FWD
    } t_cls;

    // Which result the output register loads
    typedef enum logic [2:0] {
        EM_DAC_HI,
        EM_DAC_LO,
        EM_ROUTE,
        EM_LED,
        EM_FWD
    } t_emit_sel;

    typedef struct packed {
        logic      store;
        logic      clear_len;
        logic      init_parse;
        logic      init_fwd;
        logic      adv;
        logic      set_neg;
        logic      acc_step;
        logic      finish;
        logic      emit;
        t_emit_sel emit_sel;
        logic      last;
        logic      route_upd;
    } t_dp_cmd;

    typedef struct packed {
        t_cls cls;
        logic byte_nl;
        logic byte_cr;
        logic cur_space;
        logic cur_sign;
        logic cur_digit;
        logic fwd_end;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/scl_dp.sv =====
// Datapath: line store, value parser registers, route byte and result register.
`default_nettype none

module scl_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_byte_in,
    input  wire logic                 i_stall,
    input  wire scl_pkg::t_dp_cmd     i_cmd,
    output scl_pkg::t_dp_status       o_status,
    output logic                      o_valid,
    output logic [1:0]                o_kind,
    output logic [3:0]                o_channel,
    output logic [7:0]                o_data_byte,
    output logic                      o_last
);

    logic [7:0]                 r_store [scl_pkg::CAP];
    logic [scl_pkg::LEN_W-1:0]  r_len;
    logic [scl_pkg::LEN_W-1:0]  r_pos;
    logic [scl_pkg::VAL_W-1:0]  r_acc;
    logic [scl_pkg::VAL_W-1:0]  r_val;
    logic                       r_neg;
    logic [7:0]                 r_route;
    logic                       r_valid;
    logic [1:0]                 r_kind;
    logic [3:0]                 r_channel;
    logic [7:0]                 r_data;
    logic                       r_last;

    logic [7:0]                 c0;
    logic [7:0]                 c1;
    logic [7:0]                 cur;
    logic [3:0]                 dac_ch;
    logic [7:0]                 n_route;
    logic [7:0]                 led_idx;
    logic [scl_pkg::VAL_W-1:0]  n_acc;
    logic                       out_free;
    scl_pkg::t_cls              cls;

    // Positions at or past the length read as terminator
    assign c0  = (r_len > scl_pkg::LEN_W'(0)) ? r_store[0] : 8'h00;
    assign c1  = (r_len > scl_pkg::LEN_W'(1)) ? r_store[1] : 8'h00;
    assign cur = (r_pos < r_len) ? r_store[r_pos[scl_pkg::IDX_W-1:0]] : 8'h00;

    always_comb begin
        cls = scl_pkg::CLS_NONE;
        case (c0) inside
            scl_pkg::CH_0: begin
                if (c1 >= scl_pkg::CH_0 && c1 <= scl_pkg::CH_7) begin
                    cls = scl_pkg::CLS_DAC;
                end
            end
            scl_pkg::CH_1: cls = scl_pkg::CLS_ROUTE;
            scl_pkg::CH_2: begin
                if (c1 == scl_pkg::CH_0 || c1 == scl_pkg::CH_1) begin
                    cls = scl_pkg::CLS_LED;
                end
            end
            [scl_pkg::CH_7:scl_pkg::CH_9]: cls = scl_pkg::CLS_FWD;
            default: cls = scl_pkg::CLS_NONE;
        endcase
    end

    assign out_free = !r_valid || !i_stall;

    always_comb begin
        o_status.cls       = cls;
        o_status.byte_nl   = (i_byte_in == scl_pkg::CH_NL);
        o_status.byte_cr   = (i_byte_in == scl_pkg::CH_CR);
        o_status.cur_space = (cur == scl_pkg::CH_SPACE)
                          || (cur >= scl_pkg::CH_TAB && cur <= scl_pkg::CH_CR);
        o_status.cur_sign  = (cur == scl_pkg::CH_PLUS) || (cur == scl_pkg::CH_MINUS);
        o_status.cur_digit = (cur >= scl_pkg::CH_0) && (cur <= scl_pkg::CH_9);
        o_status.fwd_end   = (r_pos == r_len);
        o_status.out_free  = out_free;
    end

    // acc * 10 + digit, wrapping at the value width
    assign n_acc = {r_acc[scl_pkg::VAL_W-4:0], 3'b000}
                 + {r_acc[scl_pkg::VAL_W-2:0], 1'b0}
                 + scl_pkg::VAL_W'(cur[3:0]);

    assign dac_ch  = scl_pkg::DAC_MAP[c1[2:0]];
    assign n_route = {(r_val != '0), r_route[6:0]};

    // Saturate the gamma index to 0..255
    always_comb begin
        if (r_val[scl_pkg::VAL_W-1]) begin
            led_idx = 8'h00;
        end else if (|r_val[scl_pkg::VAL_W-2:8]) begin
            led_idx = 8'hFF;
        end else begin
            led_idx = r_val[7:0];
        end
    end

    // Line store holds no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && r_len < scl_pkg::LEN_W'(scl_pkg::CAP)) begin
            r_store[r_len[scl_pkg::IDX_W-1:0]] <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_route <= scl_pkg::ROUTE_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_len) begin
                r_len <= '0;
            end else if (i_cmd.store && r_len < scl_pkg::LEN_W'(scl_pkg::CAP)) begin
                r_len <= r_len + scl_pkg::LEN_W'(1);
            end
            if (i_cmd.route_upd) begin
                r_route <= n_route;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_parse) begin
            r_pos <= scl_pkg::PARSE_START;
        end else if (i_cmd.init_fwd) begin
            r_pos <= '0;
        end else if (i_cmd.adv) begin
            r_pos <= r_pos + scl_pkg::LEN_W'(1);
        end
        if (i_cmd.init_parse) begin
            r_acc <= '0;
            r_neg <= 1'b0;
        end else begin
            if (i_cmd.acc_step) begin
                r_acc <= n_acc;
            end
            if (i_cmd.set_neg) begin
                r_neg <= (cur == scl_pkg::CH_MINUS);
            end
        end
        if (i_cmd.finish) begin
            r_val <= r_neg ? (scl_pkg::VAL_W'(0) - r_acc) : r_acc;
        end
        if (i_cmd.emit) begin
            r_last <= i_cmd.last;
            case (i_cmd.emit_sel)
                scl_pkg::EM_DAC_HI: begin
                    r_kind    <= scl_pkg::KIND_DAC;
                    r_channel <= dac_ch;
                    r_data    <= {dac_ch, 4'h0} | r_val[13:6];
                end
                scl_pkg::EM_DAC_LO: begin
                    r_kind    <= scl_pkg::KIND_DAC;
                    r_channel <= dac_ch;
                    r_data    <= {r_val[5:0], 2'b00};
                end
                scl_pkg::EM_ROUTE: begin
                    r_kind    <= scl_pkg::KIND_ROUTE;
                    r_channel <= 4'h0;
                    r_data    <= n_route;
                end
                scl_pkg::EM_LED: begin
                    r_kind    <= scl_pkg::KIND_LED;
                    r_channel <= {3'b000, c1[0]};
                    r_data    <= scl_pkg::GAMMA_ROM[led_idx];
                end
                default: begin
                    r_kind    <= scl_pkg::KIND_FWD;
                    r_channel <= 4'h0;
                    r_data    <= cur;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_channel   = r_channel;
    assign o_data_byte = r_data;
    assign o_last      = r_last;

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= scl_pkg::LEN_W'(scl_pkg::CAP))
        else $error("line length beyond capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded over an unaccepted result");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_len |=> r_len == '0)
        else $error("line not emptied after decode");

endmodule

`default_nettype wire

// ===== hdl/scl_ctrl.sv =====
// Controller: sequences line capture, value parsing and result emission.
`default_nettype none

module scl_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire scl_pkg::t_dp_status  i_status,
    output scl_pkg::t_dp_cmd          o_cmd,
    output logic                      o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP,
        S_DIGIT,
        S_FIN,
        S_EMIT,
        S_EMIT2,
        S_FWD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_status.byte_nl) begin
                        case (i_status.cls)
                            scl_pkg::CLS_NONE: o_cmd.clear_len = 1'b1;
                            scl_pkg::CLS_FWD: begin
                                o_cmd.init_fwd = 1'b1;
                                n_state        = S_FWD;
                            end
                            default: begin
                                o_cmd.init_parse = 1'b1;
                                n_state          = S_SKIP;
                            end
                        endcase
                    end else if (!i_status.byte_cr) begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            S_SKIP: begin
                if (i_status.cur_space) begin
                    o_cmd.adv = 1'b1;
                end else begin
                    if (i_status.cur_sign) begin
                        o_cmd.set_neg = 1'b1;
                        o_cmd.adv     = 1'b1;
                    end
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.cur_digit) begin
                    o_cmd.acc_step = 1'b1;
                    o_cmd.adv      = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    case (i_status.cls)
                        scl_pkg::CLS_DAC: begin
                            o_cmd.emit_sel = scl_pkg::EM_DAC_HI;
                            n_state        = S_EMIT2;
                        end
                        scl_pkg::CLS_ROUTE: begin
                            o_cmd.emit_sel  = scl_pkg::EM_ROUTE;
                            o_cmd.route_upd = 1'b1;
                            o_cmd.last      = 1'b1;
                            o_cmd.clear_len = 1'b1;
                            n_state         = S_IDLE;
                        end
                        default: begin
                            o_cmd.emit_sel  = scl_pkg::EM_LED;
                            o_cmd.last      = 1'b1;
                            o_cmd.clear_len = 1'b1;
                            n_state         = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT2: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = scl_pkg::EM_DAC_LO;
                    o_cmd.last      = 1'b1;
                    o_cmd.clear_len = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FWD: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = scl_pkg::EM_FWD;
                    o_cmd.adv      = 1'b1;
                    if (i_status.fwd_end) begin
                        o_cmd.last      = 1'b1;
                        o_cmd.clear_len = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_fwd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWD && o_cmd.emit && o_cmd.last) |=> r_state == S_IDLE)
        else $error("forwarding did not finish on the terminator");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.store || o_cmd.init_parse || o_cmd.init_fwd) |-> r_state == S_IDLE)
        else $error("byte taken while a line is being decoded");

endmodule

`default_nettype wire

// ===== hdl/serial_command_line_decoder.sv =====
// Top level of the serial command line decoder.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------------
//  input    | in        | i_valid / o_stall | i_byte_in
//  output   | out       | o_valid / i_stall | o_kind, o_channel, o_data_byte, o_last
//
// Any byte other than a newline is taken while no decode runs. A newline starts a
// decode: leading blanks are skipped, an optional sign is taken, the digits are
// accumulated and closed and the value is formed, then the results are emitted;
// forwarding emits line length + 1 results and nothing else. A line with a bad
// target or subtarget is dropped in the newline's own cycle. The controller runs a
// single decode sequence at a time; o_stall is high while it runs.
// Reset (i_rst_n low, synchronous) empties the line and sets the route byte to 63.
// A stall on the output holds the result register and pauses the decode at its next result.
`default_nettype none

module serial_command_line_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_channel,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);

    scl_pkg::t_dp_cmd    dp_cmd;
    scl_pkg::t_dp_status dp_status;
    logic                busy;
    logic                in_accept;

    // Take a byte only while no line is being decoded
    assign o_stall   = busy;
    assign in_accept = i_valid && !busy;

    scl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // Hold the line, parse the value and drive the result transfer
    scl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_in   (i_byte_in),
        .i_stall     (i_stall),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_channel   (o_channel),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the serial command line decoder: command lines in, transfers checked.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 380;      // stored characters plus newlines
    localparam int LONG_HOLD    = 300;      // receiver hold-off that backs up the decoder
    localparam int DRAIN_CYCLES = 80;       // worst decode plus a stalled output burst
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int MAX_REPORTS  = 10;

    // One bus transfer as it appears on the output channel
    typedef struct {
        logic [1:0] kind;
        logic [3:0] channel;
        logic [7:0] data_byte;
        logic       last;
    } t_transfer;

    // Mirror of the line buffer and route byte; predicts the transfers of each line
    class command_line_tracker;
        logic [7:0]  line_chars [scl_pkg::CAP];
        int unsigned line_len;
        logic [7:0]  route;
        t_transfer   pending_transfers [$];
        int unsigned faults;

        function new();
            line_len = 0;
            route    = scl_pkg::ROUTE_RESET;
            faults   = 0;
        endfunction

        function void flag_fault(string msg);
            faults++;
            if (faults <= MAX_REPORTS) $display("%t mismatch: %s", $time, msg);
        endfunction

        // Positions past the end of the line read as a terminator
        function logic [7:0] char_at(int unsigned pos);
            return (pos < line_len) ? line_chars[pos] : 8'h00;
        endfunction

        function void expect_transfer(logic [1:0] kind, logic [3:0] chan, logic [7:0] data,
                                      logic last);
            pending_transfers.push_back(t_transfer'{kind, chan, data, last});
        endfunction

        function void decode_line();
            logic [7:0]  tgt;
            logic [7:0]  sub;
            logic [7:0]  c;
            logic [7:0]  idx;
            logic [3:0]  chan;
            logic [31:0] val;
            logic        negate;
            int unsigned pos;
            int unsigned i;
            tgt = char_at(0);
            sub = char_at(1);
            // Skip blanks, take an optional sign, then accumulate digits modulo 2^32
            pos    = scl_pkg::PARSE_START;
            val    = '0;
            negate = 1'b0;
            c      = char_at(pos);
            while (c == scl_pkg::CH_SPACE || (c >= scl_pkg::CH_TAB && c <= scl_pkg::CH_CR)) begin
                pos++;
                c = char_at(pos);
            end
            if (c == scl_pkg::CH_PLUS || c == scl_pkg::CH_MINUS) begin
                negate = (c == scl_pkg::CH_MINUS);
                pos++;
                c = char_at(pos);
            end
            while (c >= scl_pkg::CH_0 && c <= scl_pkg::CH_9) begin
                val = val * 32'd10 + 32'(c - scl_pkg::CH_0);
                pos++;
                c = char_at(pos);
            end
            if (negate) val = -val;

            case (tgt)
                scl_pkg::CH_0: begin
                    // '0'..'7' select the channel through DAC_MAP by their low three bits
                    if (sub >= scl_pkg::CH_0 && sub <= scl_pkg::CH_7) begin
                        chan = scl_pkg::DAC_MAP[sub[2:0]];
                        expect_transfer(scl_pkg::KIND_DAC, chan,
                                        {chan, 4'h0} | val[13:6], 1'b0);
                        expect_transfer(scl_pkg::KIND_DAC, chan,
                                        {val[5:0], 2'b00}, 1'b1);
                    end
                end
                scl_pkg::CH_1: begin
                    route[7] = (val != 32'd0);
                    expect_transfer(scl_pkg::KIND_ROUTE, 4'd0, route, 1'b1);
                end
                scl_pkg::CH_2: begin
                    if (sub == scl_pkg::CH_0 || sub == scl_pkg::CH_1) begin
                        if (val[31])
                            idx = 8'h00;
                        else if (val > 32'd255)
                            idx = 8'hFF;
                        else
                            idx = val[7:0];
                        expect_transfer(scl_pkg::KIND_LED, {3'b000, sub[0]},
                                        scl_pkg::GAMMA_ROM[idx], 1'b1);
                    end
                end
                scl_pkg::CH_7, scl_pkg::CH_8, scl_pkg::CH_9: begin
                    for (i = 0; i < line_len; i++)
                        expect_transfer(scl_pkg::KIND_FWD, 4'd0, line_chars[i], 1'b0);
                    expect_transfer(scl_pkg::KIND_FWD, 4'd0, 8'h00, 1'b1);
                end
                default: ;
            endcase
        endfunction

        // Note an accepted byte; returns 1 when the byte was not simply dropped
        function bit note_byte(logic [7:0] b);
            if (b == scl_pkg::CH_NL) begin
                decode_line();
                line_len = 0;
                return 1'b1;
            end
            if (b == scl_pkg::CH_CR || line_len >= scl_pkg::CAP) return 1'b0;
            line_chars[line_len] = b;
            line_len++;
            return 1'b1;
        endfunction

        function void check_transfer(t_transfer got);
            t_transfer want;
            if (pending_transfers.size() == 0) begin
                flag_fault($sformatf("unexpected transfer kind=%0d chan=%0d data=%02h last=%0b",
                                     got.kind, got.channel, got.data_byte, got.last));
                return;
            end
            want = pending_transfers.pop_front();
            if (got.kind !== want.kind || got.channel !== want.channel ||
                got.data_byte !== want.data_byte || got.last !== want.last)
                flag_fault($sformatf({"expected kind=%0d chan=%0d data=%02h last=%0b, ",
                                      "got kind=%0d chan=%0d data=%02h last=%0b"},
                                     want.kind, want.channel, want.data_byte, want.last,
                                     got.kind, got.channel, got.data_byte, got.last));
        endfunction
    endclass

    // Block inputs hold known values from time zero
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_byte_in = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [3:0] o_channel;
    logic [7:0] o_data_byte;
    logic       o_last;

    command_line_tracker tracker = new();
    int unsigned taken_items  = 0;
    bit          calm         = 1'b0;   // both sides run without gaps while set
    bit          hold_request = 1'b0;   // ask the receiver for one long hold-off

    serial_command_line_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_byte_in   (i_byte_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_channel   (o_channel),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Sample both channels at the edge, before any update scheduled for that edge lands
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (tracker.note_byte(i_byte_in)) taken_items++;
        end
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_transfer(t_transfer'{o_kind, o_channel, o_data_byte, o_last});
    end

    // Offer one byte after a random gap (none while calm), then hold it until taken.
    // Valid stays high on return so back-to-back bytes never drop it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Build one line: mostly a well-formed command with random content, sometimes
    // corrupted, overlong, broken by a carriage return, or plain noise
    task automatic send_command_line();
        logic [7:0] text [$];
        int         pick;
        int         n;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            n = $urandom_range(1, 12);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            // target digit, weighted towards the ones that act
            pick = $urandom_range(0, 99);
            if (pick < 20)      text.push_back(scl_pkg::CH_0);
            else if (pick < 35) text.push_back(scl_pkg::CH_1);
            else if (pick < 55) text.push_back(scl_pkg::CH_2);
            else if (pick < 63) text.push_back(scl_pkg::CH_7);
            else if (pick < 71) text.push_back(scl_pkg::CH_8);
            else if (pick < 79) text.push_back(scl_pkg::CH_9);
            else if (pick < 92) text.push_back(8'(scl_pkg::CH_0 + $urandom_range(3, 6)));
            else                text.push_back(8'($urandom_range(0, 255)));
            // subtarget: mostly in range for the target, else any digit or any byte
            pick = $urandom_range(0, 99);
            if (pick < 80)
                text.push_back(8'(scl_pkg::CH_0 + ((text[0] == scl_pkg::CH_2)
                                                   ? $urandom_range(0, 1)
                                                   : $urandom_range(0, 7))));
            else if (pick < 92)
                text.push_back(8'(scl_pkg::CH_0 + $urandom_range(0, 9)));
            else
                text.push_back(8'($urandom_range(0, 255)));
            // position 2 is never parsed
            text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : scl_pkg::CH_SPACE);
            // leading blanks; CR and newline are left out as they never reach the store
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       text.push_back(scl_pkg::CH_TAB);
                    1:       text.push_back(8'h0B);
                    2:       text.push_back(8'h0C);
                    default: text.push_back(scl_pkg::CH_SPACE);
                endcase
            end
            case ($urandom_range(0, 5))
                0:       text.push_back(scl_pkg::CH_MINUS);
                1:       text.push_back(scl_pkg::CH_PLUS);
                default: ;
            endcase
            // short values keep the LED index around its saturation points
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3);
            repeat (n) text.push_back(8'(scl_pkg::CH_0 + $urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0)
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            // overrun the line capacity now and then
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 6);
                repeat (n) text.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 7) == 0)
            text.insert($urandom_range(0, text.size() - 1), scl_pkg::CH_CR);
        text.push_back(scl_pkg::CH_NL);
        foreach (text[i]) send_byte(text[i]);
    endtask

    // Receiver: draw a stall per transfer, or serve one long hold-off when asked
    initial begin : receiver
        int hold;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned lines_sent;
        bit          hold_done;
        lines_sent = 0;
        hold_done  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short line: value reads the terminator, clears the route bit
        send_text("1");
        send_byte(scl_pkg::CH_NL);
        // DAC on the highest subtarget with a negative value; drop the carriage return
        send_text("07 -1");
        send_byte(scl_pkg::CH_CR);
        send_byte(scl_pkg::CH_NL);
        // LED level above the table range saturates
        send_text("21 300");
        send_byte(scl_pkg::CH_NL);
        // Forward a full line holding both byte extremes; the tail is dropped as overflow
        send_byte(scl_pkg::CH_9);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("ABCDEFGHI");
        send_byte(scl_pkg::CH_NL);

        while (taken_items < ITEM_TARGET) begin
            if (lines_sent % 8 == 0) calm = ($urandom_range(0, 3) == 0);
            // Stall the output for a long stretch while bytes keep coming
            if (!hold_done && taken_items > ITEM_TARGET / 3) begin
                calm         = 1'b0;
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            send_command_line();
            lines_sent++;
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // Let the last newline's transfers land, then watch for strays
        @(posedge i_clk);
        while (tracker.pending_transfers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending_transfers.size() != 0)
            tracker.flag_fault($sformatf("%0d transfers never arrived",
                                         tracker.pending_transfers.size()));

        if (tracker.faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/scl_pkg.sv
hdl/scl_dp.sv
hdl/scl_ctrl.sv
hdl/serial_command_line_decoder.sv
bench/tb.sv
